@@ rtl/ficm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ficm_pkg;

    localparam int STAMP_BITS = 48;
    localparam int COUNT_BITS = 32;
    localparam int SUM_BITS   = 64;
    localparam int FPS_BITS   = 10;
    // 1000000 fits in 20 bits; so does any period
    localparam int PER_BITS   = 20;
    localparam int STEP_BITS  = $clog2(STAMP_BITS + 1);

    localparam logic [FPS_BITS-1:0]   FPS_RESET      = FPS_BITS'(60);
    localparam logic [PER_BITS-1:0]   MICROS_PER_SEC = PER_BITS'(1000000);
    // left-aligned so a PER_BITS-step pass leaves the quotient in the low bits
    localparam logic [STAMP_BITS-1:0] PERIOD_DIVIDEND =
        {MICROS_PER_SEC, {(STAMP_BITS - PER_BITS){1'b0}}};

    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [STAMP_BITS-1:0] timestamp_us;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_BITS-1:0] frame_count;
        logic                  interval_valid;
        logic [STAMP_BITS-1:0] last_interval_us;
        logic [COUNT_BITS-1:0] interval_count;
        logic [SUM_BITS-1:0]   interval_sum_us;
        logic [STAMP_BITS-1:0] interval_max_us;
        logic                  late_flag;
        logic [COUNT_BITS-1:0] late_count;
        logic [STAMP_BITS-1:0] missed_now;
        logic [COUNT_BITS-1:0] missed_total;
    } t_out_beat;

    typedef struct packed {
        logic latch;
        logic start_period;
        logic take_period;
        logic start_quot;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic measure;
        logic late;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/ficm_chan_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ficm_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/frame_interval_cadence_monitor_core.sv @@
// One item at a time: a cadence reset or an unmeasured frame goes from evaluation to commit,
// an on-time interval adds the period division, and a late one adds the quotient division too.
// The next beat can be taken in the cycle after the result is written. The shared bit-serial
// divider sets the pace (20 steps for the period, 48 more for interval / period).
// Synchronous active-low reset clears all statistics, sets the frame rate register to 60
// and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module frame_interval_cadence_monitor_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ficm_chan_if.sink   i_in,
    ficm_chan_if.source o_out,
    ficm_chan_if.sink   i_cfg
);
    import ficm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    logic cfg_we;

    // config is always taken; it only lands in the fps register
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // input beat accepted only by the controller in its idle state
    assign i_in.ready = in_ready;

    ficm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: stats registers, shared divider, result register
    ficm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in.data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

    assign o_out.valid = out_valid;

    // the period pass is only started for an item that measures an interval
    a_period_needs_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start_period |-> sts.measure)
        else $error("period division started without a measurement");

    // the quotient pass is only started for a late interval
    a_quot_needs_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start_quot |-> sts.late)
        else $error("quotient division started for an on-time interval");

    // a result is never written over one still waiting
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result register overwritten");

    // one item in flight: no beat taken right after one was taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second beat accepted while busy");

    // a late flag implies a measured interval
    a_late_has_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_out.data.late_flag) |-> o_out.data.interval_valid)
        else $error("late flag without interval");

endmodule

`default_nettype wire

@@ rtl/ficm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module ficm_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [ficm_pkg::STAMP_BITS-1:0] i_dividend,
    input  wire logic [ficm_pkg::PER_BITS-1:0]   i_divisor,
    input  wire logic [ficm_pkg::STEP_BITS-1:0]  i_steps,
    output logic                                 o_done,
    output logic [ficm_pkg::STAMP_BITS-1:0]      o_quotient,
    output logic [ficm_pkg::PER_BITS-1:0]        o_remainder
);
    import ficm_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_cnt;
    logic [STAMP_BITS-1:0] r_quo;
    logic [PER_BITS-1:0]   r_rem;
    logic [PER_BITS-1:0]   r_div;
    logic [PER_BITS:0]     rem_sh;
    logic [PER_BITS:0]     rem_diff;
    logic                  fits;

    always_comb begin
        rem_sh   = {r_rem, r_quo[STAMP_BITS-1]};
        fits     = rem_sh >= {1'b0, r_div};
        rem_diff = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_diff[PER_BITS-1:0] : rem_sh[PER_BITS-1:0];
            r_quo <= {r_quo[STAMP_BITS-2:0], fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

@@ rtl/ficm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ficm_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ficm_pkg::t_cmd                i_cmd,
    output ficm_pkg::t_sts                     o_sts,
    input  wire ficm_pkg::t_in_beat            i_in_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [ficm_pkg::FPS_BITS-1:0] i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output ficm_pkg::t_out_beat                o_out_data
);
    import ficm_pkg::*;

    // item under work
    logic                  r_func;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [STAMP_BITS-1:0] r_ivl;
    logic [PER_BITS-1:0]   r_period;

    // config and statistics
    logic [FPS_BITS-1:0]   r_fps;
    logic [STAMP_BITS-1:0] r_prev;
    logic [STAMP_BITS-1:0] r_recent;
    logic [COUNT_BITS-1:0] r_frames;
    logic [COUNT_BITS-1:0] r_intervals;
    logic [SUM_BITS-1:0]   r_sum;
    logic [STAMP_BITS-1:0] r_peak;
    logic [COUNT_BITS-1:0] r_late_cnt;
    logic [COUNT_BITS-1:0] r_missed_tot;

    logic                  r_out_valid;
    t_out_beat             r_out;

    logic [STAMP_BITS-1:0] n_prev;
    logic [STAMP_BITS-1:0] n_recent;
    logic [COUNT_BITS-1:0] n_frames;
    logic [COUNT_BITS-1:0] n_intervals;
    logic [SUM_BITS-1:0]   n_sum;
    logic [STAMP_BITS-1:0] n_peak;
    logic [COUNT_BITS-1:0] n_late_cnt;
    logic [COUNT_BITS-1:0] n_missed_tot;
    t_out_beat             n_out;

    logic                  measure;
    logic                  late_cmp;
    logic                  late_now;
    logic                  round_up;
    logic [STAMP_BITS-1:0] ivl;
    logic [STAMP_BITS-1:0] missed;
    logic [PER_BITS-1:0]   half;
    logic [PER_BITS:0]     limit;
    logic [PER_BITS-1:0]   fps_eff;

    logic                  div_start;
    logic                  div_done;
    logic [STAMP_BITS-1:0] div_dividend;
    logic [PER_BITS-1:0]   div_divisor;
    logic [STEP_BITS-1:0]  div_steps;
    logic [STAMP_BITS-1:0] div_quo;
    logic [PER_BITS-1:0]   div_rem;

    always_comb begin
        ivl      = r_stamp - r_prev;
        measure  = (r_func == FUNC_FRAME) && (r_prev != '0) && (r_stamp > r_prev);
        fps_eff  = (r_fps == '0) ? PER_BITS'(1) : PER_BITS'(r_fps);
        half     = r_period >> 1;
        limit    = {1'b0, r_period} + {1'b0, half};
        late_cmp = r_ivl > STAMP_BITS'(limit);
        late_now = measure && late_cmp;
        // half-up rounding of ivl / period
        round_up = div_rem >= (r_period - half);
        missed   = div_quo + STAMP_BITS'(round_up) - STAMP_BITS'(1);
    end

    always_comb begin
        div_start    = i_cmd.start_period || i_cmd.start_quot;
        div_dividend = i_cmd.start_period ? PERIOD_DIVIDEND : r_ivl;
        div_divisor  = i_cmd.start_period ? fps_eff : r_period;
        div_steps    = i_cmd.start_period ? STEP_BITS'(PER_BITS) : STEP_BITS'(STAMP_BITS);
    end

    ficm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .i_steps     (div_steps),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_prev       = r_prev;
        n_recent     = r_recent;
        n_frames     = r_frames;
        n_intervals  = r_intervals;
        n_sum        = r_sum;
        n_peak       = r_peak;
        n_late_cnt   = r_late_cnt;
        n_missed_tot = r_missed_tot;
        if (r_func == FUNC_RESET) begin
            n_prev   = '0;
            n_recent = '0;
        end else begin
            n_frames = r_frames + COUNT_BITS'(1);
            n_prev   = r_stamp;
            if (measure) begin
                n_recent    = r_ivl;
                n_intervals = r_intervals + COUNT_BITS'(1);
                n_sum       = r_sum + SUM_BITS'(r_ivl);
                if (r_ivl > r_peak) begin
                    n_peak = r_ivl;
                end
                if (late_cmp) begin
                    n_late_cnt   = r_late_cnt + COUNT_BITS'(1);
                    n_missed_tot = r_missed_tot + missed[COUNT_BITS-1:0];
                end
            end
        end

        n_out.frame_count      = n_frames;
        n_out.interval_valid   = measure;
        n_out.last_interval_us = n_recent;
        n_out.interval_count   = n_intervals;
        n_out.interval_sum_us  = n_sum;
        n_out.interval_max_us  = n_peak;
        n_out.late_flag        = late_now;
        n_out.late_count       = n_late_cnt;
        n_out.missed_now       = late_now ? missed : '0;
        n_out.missed_total     = n_missed_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps        <= FPS_RESET;
            r_prev       <= '0;
            r_recent     <= '0;
            r_frames     <= '0;
            r_intervals  <= '0;
            r_sum        <= '0;
            r_peak       <= '0;
            r_late_cnt   <= '0;
            r_missed_tot <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fps <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_prev       <= n_prev;
                r_recent     <= n_recent;
                r_frames     <= n_frames;
                r_intervals  <= n_intervals;
                r_sum        <= n_sum;
                r_peak       <= n_peak;
                r_late_cnt   <= n_late_cnt;
                r_missed_tot <= n_missed_tot;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= i_in_data.func;
            r_stamp <= i_in_data.timestamp_us;
        end
        if (i_cmd.start_period) begin
            r_ivl <= ivl;
        end
        if (i_cmd.take_period) begin
            r_period <= div_quo[PER_BITS-1:0];
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_sts.measure  = measure;
        o_sts.late     = late_cmp;
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ rtl/ficm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ficm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ficm_pkg::t_sts i_sts,
    output ficm_pkg::t_cmd      o_cmd
);
    import ficm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_PERIOD = 6'b000100,
        S_CHECK  = 6'b001000,
        S_QUOT   = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.measure) begin
                    o_cmd.start_period = 1'b1;
                    n_state            = S_PERIOD;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_PERIOD: begin
                if (i_sts.div_done) begin
                    o_cmd.take_period = 1'b1;
                    n_state           = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.late) begin
                    o_cmd.start_quot = 1'b1;
                    n_state          = S_QUOT;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_QUOT: begin
                if (i_sts.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ dv/tb_frame_interval_cadence_monitor_core.sv @@
`timescale 1ns / 1ps

module tb_frame_interval_cadence_monitor_core;
    import ficm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 15;
    localparam int PHASE_BEATS  = 100;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int PRINT_CAP    = 40;

    typedef enum logic {ROW_BEAT, ROW_FPS} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        t_in_beat            beat;
        logic [FPS_BITS-1:0] fps;
        bit                  pinned;
        t_out_beat           want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    ficm_chan_if #(.T(t_in_beat))            in_if  ();
    ficm_chan_if #(.T(t_out_beat))           out_if ();
    ficm_chan_if #(.T(logic [FPS_BITS-1:0])) cfg_if ();

    frame_interval_cadence_monitor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Cadence tracker mirror: same state the block keeps, plus the fps register.
    logic [FPS_BITS-1:0]   cad_fps;
    logic [STAMP_BITS-1:0] cad_prev;
    logic [STAMP_BITS-1:0] cad_last;
    logic [COUNT_BITS-1:0] cad_frames;
    logic [COUNT_BITS-1:0] cad_ivls;
    logic [SUM_BITS-1:0]   cad_sum;
    logic [STAMP_BITS-1:0] cad_peak;
    logic [COUNT_BITS-1:0] cad_lates;
    logic [COUNT_BITS-1:0] cad_missed;

    t_out_beat stats_due_q[$];
    t_out_beat due_stats;
    t_stim_row stim_rows[$];

    int unsigned cycles;
    int          errors;
    bit          idle_on;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run guard: the slowest legal run is far below this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [STAMP_BITS-1:0] rand48();
        return STAMP_BITS'({$urandom(), $urandom()});
    endfunction

    // Target period in us; a zero rate counts as one frame per second.
    function automatic logic [63:0] period_us(logic [FPS_BITS-1:0] fps);
        return 64'd1000000 / ((fps == '0) ? 64'd1 : 64'(fps));
    endfunction

    // Advance the mirrored statistics by one beat and return what the block should report.
    function automatic t_out_beat track_cadence(t_in_beat b);
        t_out_beat             r;
        logic [STAMP_BITS-1:0] prior;
        logic [63:0]           ivl, per, half, quo, rem, refr;
        r = '0;
        if (b.func == FUNC_RESET) begin
            // cadence reset: forget the last stamp and interval, keep the totals
            cad_prev = '0;
            cad_last = '0;
        end else begin
            prior      = cad_prev;
            cad_frames = cad_frames + 1'b1;
            cad_prev   = b.timestamp_us;
            // after a zero stamp, or with a non-advancing stamp, only the frame is counted
            if (prior != '0 && b.timestamp_us > prior) begin
                ivl  = 64'(b.timestamp_us - prior);
                per  = period_us(cad_fps);
                half = per / 2;
                r.interval_valid = 1'b1;
                cad_last = ivl[STAMP_BITS-1:0];
                cad_ivls = cad_ivls + 1'b1;
                cad_sum  = cad_sum + ivl;
                if (ivl[STAMP_BITS-1:0] > cad_peak)
                    cad_peak = ivl[STAMP_BITS-1:0];
                // late beyond 1.5 periods; missed = round-half-up(ivl / per) - 1
                if (ivl > per + half) begin
                    quo  = ivl / per;
                    rem  = ivl % per;
                    refr = quo + ((rem >= per - half) ? 64'd1 : 64'd0);
                    if (refr < 64'd1)
                        refr = 64'd1;
                    r.late_flag  = 1'b1;
                    r.missed_now = STAMP_BITS'(refr - 64'd1);
                    cad_lates    = cad_lates + 1'b1;
                    cad_missed   = cad_missed + COUNT_BITS'(refr - 64'd1);
                end
            end
        end
        r.frame_count      = cad_frames;
        r.last_interval_us = cad_last;
        r.interval_count   = cad_ivls;
        r.interval_sum_us  = cad_sum;
        r.interval_max_us  = cad_peak;
        r.late_count       = cad_lates;
        r.missed_total     = cad_missed;
        return r;
    endfunction

    task automatic check_field(string tag, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t ns %s expected %0d actual %0d", $time, tag, want, got);
        end
    endtask

    // Result side: every beat taken from the block is matched to the oldest pending stats.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (stats_due_q.size() == 0) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t ns stray result beat expected none actual frame_count %0d",
                             $time, out_if.data.frame_count);
            end else begin
                due_stats = stats_due_q.pop_front();
                check_field("frame_count", 64'(due_stats.frame_count),
                            64'(out_if.data.frame_count));
                check_field("interval_valid", 64'(due_stats.interval_valid),
                            64'(out_if.data.interval_valid));
                check_field("last_interval_us", 64'(due_stats.last_interval_us),
                            64'(out_if.data.last_interval_us));
                check_field("interval_count", 64'(due_stats.interval_count),
                            64'(out_if.data.interval_count));
                check_field("interval_sum_us", due_stats.interval_sum_us,
                            out_if.data.interval_sum_us);
                check_field("interval_max_us", 64'(due_stats.interval_max_us),
                            64'(out_if.data.interval_max_us));
                check_field("late_flag", 64'(due_stats.late_flag),
                            64'(out_if.data.late_flag));
                check_field("late_count", 64'(due_stats.late_count),
                            64'(out_if.data.late_count));
                check_field("missed_now", 64'(due_stats.missed_now),
                            64'(out_if.data.missed_now));
                check_field("missed_total", 64'(due_stats.missed_total),
                            64'(out_if.data.missed_total));
            end
        end
    end

    // Result-side ready: random stall bursts, or one long hold-off on request.
    initial begin
        int burst;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 9);
                out_if.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Sender tasks start at a negedge-bound step and return right after the accepting edge.
    task automatic send_beat(t_in_beat b, bit pinned, t_out_beat want);
        t_out_beat guess;
        int        gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        do @(posedge i_clk); while (!in_if.ready);
        guess = track_cadence(b);
        stats_due_q.push_back(pinned ? want : guess);
    endtask

    task automatic drain_results();
        while (stats_due_q.size() != 0)
            @(posedge i_clk);
    endtask

    // fps is only changed with the block idle: input quiet and all stats back.
    task automatic write_fps(logic [FPS_BITS-1:0] v);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        drain_results();
        repeat (4) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cad_fps = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void add_beat(logic func, logic [STAMP_BITS-1:0] stamp);
        t_stim_row row;
        row.kind   = ROW_BEAT;
        row.beat   = '{func: func, timestamp_us: stamp};
        row.fps    = '0;
        row.pinned = 1'b0;
        row.want   = '0;
        stim_rows.push_back(row);
    endfunction

    // Frame beat whose stats are plain to read: on time or unmeasured, no late history.
    function automatic void add_pin(logic [STAMP_BITS-1:0] stamp, int fc, bit iv,
                                    logic [STAMP_BITS-1:0] last, int ic,
                                    logic [SUM_BITS-1:0] sum, logic [STAMP_BITS-1:0] mx);
        t_stim_row row;
        row.kind   = ROW_BEAT;
        row.beat   = '{func: FUNC_FRAME, timestamp_us: stamp};
        row.fps    = '0;
        row.pinned = 1'b1;
        row.want   = '0;
        row.want.frame_count      = COUNT_BITS'(fc);
        row.want.interval_valid   = iv;
        row.want.last_interval_us = last;
        row.want.interval_count   = COUNT_BITS'(ic);
        row.want.interval_sum_us  = sum;
        row.want.interval_max_us  = mx;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_fps(logic [FPS_BITS-1:0] v);
        t_stim_row row;
        row.kind   = ROW_FPS;
        row.beat   = '0;
        row.fps    = v;
        row.pinned = 1'b0;
        row.want   = '0;
        stim_rows.push_back(row);
    endfunction

    initial begin
        t_in_beat              b;
        logic [STAMP_BITS-1:0] cursor;
        logic [STAMP_BITS-1:0] ivl;
        logic [63:0]           per;
        logic [FPS_BITS-1:0]   fps_pick;
        int                    pick;
        int                    mode;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        idle_on      = 1'b0;
        hold_req     = 1'b0;
        cycles       = 0;
        errors       = 0;

        cad_fps    = FPS_RESET;
        cad_prev   = '0;
        cad_last   = '0;
        cad_frames = '0;
        cad_ivls   = '0;
        cad_sum    = '0;
        cad_peak   = '0;
        cad_lates  = '0;
        cad_missed = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset rate of 60 fps first (period 16666 us, late above 24999).
        add_pin(48'd0, 1, 1'b0, 48'd0, 0, 64'd0, 48'd0);               // zero stamp stored
        add_pin(48'd1000, 2, 1'b0, 48'd0, 0, 64'd0, 48'd0);            // prev zero, no interval
        add_pin(48'd17666, 3, 1'b1, 48'd16666, 1, 64'd16666, 48'd16666);
        add_beat(FUNC_FRAME, 48'd17666);                               // same stamp
        add_beat(FUNC_FRAME, 48'd17000);                               // older stamp
        add_beat(FUNC_FRAME, 48'd42000);                               // 25000: just late
        add_beat(FUNC_FRAME, 48'd66999);                               // 24999: on time
        add_beat(FUNC_FRAME, 48'd166999);                              // six periods
        add_beat(FUNC_RESET, 48'hFFFF_FFFF_FFFF);
        add_beat(FUNC_FRAME, 48'hFFFF_FFFF_FFFF);                      // after reset, no interval
        add_beat(FUNC_RESET, 48'd0);
        add_beat(FUNC_FRAME, 48'd1);
        add_beat(FUNC_FRAME, 48'hFFFF_FFFF_FFFF);                      // widest interval
        add_beat(FUNC_FRAME, 48'd0);
        add_beat(FUNC_FRAME, 48'd5);
        add_fps(10'd0);                                                // acts as 1 fps
        add_beat(FUNC_FRAME, 48'd1500006);                             // 1500001: late
        add_beat(FUNC_FRAME, 48'd3000006);                             // 1500000: on time
        add_fps(10'd1023);                                             // period 977
        add_beat(FUNC_FRAME, 48'd3001472);                             // 1466: late
        add_beat(FUNC_FRAME, 48'd3002937);                             // 1465: on time
        add_beat(FUNC_FRAME, 48'd3006356);                             // rounds down
        add_fps(10'd1000);                                             // period 1000
        add_beat(FUNC_FRAME, 48'd3007856);
        add_beat(FUNC_FRAME, 48'd3009357);
        add_beat(FUNC_FRAME, 48'd3011857);                             // half rounds up

        idle_on = 1'b1;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_FPS)
                write_fps(stim_rows[i].fps);
            else
                send_beat(stim_rows[i].beat, stim_rows[i].pinned, stim_rows[i].want);
        end

        // Random phases: mostly advancing stamps with intervals shaped around the period.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph % 3 == 0) begin
                case (ph)
                    0:       fps_pick = 10'd0;
                    3:       fps_pick = 10'd1023;
                    6:       fps_pick = 10'd1;
                    12:      fps_pick = 10'd1000;
                    default: fps_pick = FPS_BITS'($urandom_range(2, 1022));
                endcase
                write_fps(fps_pick);
            end
            // quiet tail so the end runs back to back
            idle_on = (ph >= PHASES - 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (ph == 4)
                hold_req = 1'b1;
            cursor = (ph == 10) ? 48'hFFFF_0000_0000 : (rand48() >> $urandom_range(0, 20));
            per = period_us(cad_fps);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (ph == 7 && n == PHASE_BEATS / 2) begin
                    @(negedge i_clk);
                    in_if.valid <= 1'b0;
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    b = '{func: FUNC_RESET, timestamp_us: rand48()};
                end else begin
                    if (pick < 7) begin
                        b.timestamp_us = cursor - STAMP_BITS'($urandom_range(0, 3));
                    end else if (pick < 9) begin
                        b.timestamp_us = '0;
                    end else if (pick < 11) begin
                        b.timestamp_us = rand48();
                    end else begin
                        mode = $urandom_range(0, 9);
                        if (mode < 5)
                            ivl = STAMP_BITS'($urandom_range(32'(per / 2), 32'(per + per / 2)));
                        else if (mode == 5)
                            ivl = STAMP_BITS'(per + per / 2 + 64'($urandom_range(0, 1)));
                        else if (mode == 6)
                            ivl = STAMP_BITS'(64'($urandom_range(1, 8)) * per
                                              + (per - per / 2) - 64'($urandom_range(0, 1)));
                        else if (mode < 9)
                            ivl = STAMP_BITS'(64'($urandom_range(2, 40)) * per
                                              + 64'($urandom_range(0, 32'(per - 1))));
                        else
                            ivl = STAMP_BITS'({8'($urandom()), $urandom()});
                        b.timestamp_us = cursor + ivl;
                    end
                    b.func = FUNC_FRAME;
                    cursor = b.timestamp_us;
                end
                send_beat(b, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
